FILE: hdl/lpmp_pkg.sv
package lpmp_pkg;

  // Field widths of the frame format
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned LEN_SHIFT_W = 24;
  localparam int unsigned BOUND_W     = 16;
  localparam int unsigned STAMP_W     = 64;
  localparam int unsigned STAMP_SH_W  = 56;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned STATUS_W    = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W   = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SENDER  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SENDER  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CONTENT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CONTENT = 4'd3;

  // Register reset values
  localparam logic [BOUND_W-1:0] MIN_SENDER_RST  = 16'd1;
  localparam logic [BOUND_W-1:0] MAX_SENDER_RST  = 16'd64;
  localparam logic [BOUND_W-1:0] MIN_CONTENT_RST = 16'd1;
  localparam logic [BOUND_W-1:0] MAX_CONTENT_RST = 16'd4096;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_SENDER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CONTENT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;

  // Frame status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SLEN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_CLEN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TRUNC    = 2'd3;

  // Parser phase
  typedef enum logic [2:0] {
    PH_SLEN  = 3'd0,
    PH_SBODY = 3'd1,
    PH_CLEN  = 3'd2,
    PH_CBODY = 3'd3,
    PH_STAMP = 3'd4,
    PH_SKIP  = 3'd5
  } phase_t;

endpackage

FILE: hdl/length_prefixed_message_parser.sv
// Channel  Handshake             Payload
// in       in_valid / in_ready   in_data_byte, in_end_of_buffer
// out      out_valid / out_ready out_kind, out_payload_byte, out_stamp, out_status
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte is taken per cycle unless a stalled result holds the input register; a byte's result,
// when it has one, is computed from the input register and held in the result register.
// The rate is set by the single parse step between the input register and the result register.
// Reset is synchronous and active low; it restores the register defaults and the start phase.
// A stalled result holds the result register; input transfers continue until the input register
// is also full and cannot move on.
module length_prefixed_message_parser
  import lpmp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  logic                 in_end_of_buffer,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KIND_W-1:0]    out_kind,
  output logic [BYTE_W-1:0]    out_payload_byte,
  output logic [STAMP_W-1:0]   out_stamp,
  output logic [STATUS_W-1:0]  out_status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BOUND_W-1:0]   cfg_data
);

  // Configuration registers
  logic [BOUND_W-1:0] min_sender_r, max_sender_r, min_content_r, max_content_r;

  // Input register
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;

  // Parse state
  phase_t                 phase_r, phase_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [LEN_SHIFT_W-1:0] len_sh_r, len_sh_nxt;
  logic [BOUND_W-1:0]     rem_r, rem_nxt;
  logic [STAMP_SH_W-1:0]  ts_sh_r, ts_sh_nxt;

  // Result register
  logic                out_valid_r;
  logic [KIND_W-1:0]   kind_r;
  logic [BYTE_W-1:0]   pbyte_r;
  logic [STAMP_W-1:0]  stamp_r;
  logic [STATUS_W-1:0] status_r;

  // Result of the current parse step
  logic                have;
  logic [KIND_W-1:0]   kind_nxt;
  logic [BYTE_W-1:0]   pbyte_nxt;
  logic [STAMP_W-1:0]  stamp_nxt;
  logic [STATUS_W-1:0] status_nxt;

  logic               out_free, s1_adv;
  logic [LEN_W-1:0]   full_len;
  logic [BOUND_W-1:0] lo, hi;
  logic               is_sender;

  // Handshakes: the input register moves on whenever the result register has room.
  assign out_free  = !out_valid_r || out_ready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_payload_byte = pbyte_r;
  assign out_stamp        = stamp_r;
  assign out_status       = status_r;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_sender_r  <= MIN_SENDER_RST;
      max_sender_r  <= MAX_SENDER_RST;
      min_content_r <= MIN_CONTENT_RST;
      max_content_r <= MAX_CONTENT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_SENDER:  min_sender_r  <= cfg_data;
        REG_MAX_SENDER:  max_sender_r  <= cfg_data;
        REG_MIN_CONTENT: min_content_r <= cfg_data;
        REG_MAX_CONTENT: max_content_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_end_of_buffer;
    end
  end

  // Length bounds for the field being parsed
  assign is_sender = (phase_r == PH_SLEN);
  assign lo        = is_sender ? min_sender_r : min_content_r;
  assign hi        = is_sender ? max_sender_r : max_content_r;
  assign full_len  = {len_sh_r, s1_byte_r};

  // One parse step for the byte in the input register
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    len_sh_nxt = len_sh_r;
    rem_nxt    = rem_r;
    ts_sh_nxt  = ts_sh_r;
    have       = 1'b0;
    kind_nxt   = KIND_SENDER;
    pbyte_nxt  = '0;
    stamp_nxt  = '0;
    status_nxt = ST_OK;

    unique case (phase_r)
      PH_SLEN, PH_CLEN: begin
        len_sh_nxt = full_len[LEN_SHIFT_W-1:0];
        cnt_nxt    = cnt_r + 3'd1;
        // Fourth byte completes the length field.
        if (cnt_r == 3'd3) begin
          cnt_nxt    = '0;
          len_sh_nxt = '0;
          if ((full_len < {16'd0, lo}) || (full_len > {16'd0, hi})) begin
            have       = 1'b1;
            kind_nxt   = KIND_DONE;
            status_nxt = is_sender ? ST_BAD_SLEN : ST_BAD_CLEN;
            phase_nxt  = PH_SKIP;
          end else begin
            rem_nxt = full_len[BOUND_W-1:0];
            if (is_sender) begin
              phase_nxt = (full_len != '0) ? PH_SBODY : PH_CLEN;
            end else begin
              phase_nxt = (full_len != '0) ? PH_CBODY : PH_STAMP;
            end
          end
        end
      end
      PH_SBODY, PH_CBODY: begin
        have      = 1'b1;
        kind_nxt  = (phase_r == PH_SBODY) ? KIND_SENDER : KIND_CONTENT;
        pbyte_nxt = s1_byte_r;
        rem_nxt   = rem_r - 16'd1;
        if (rem_r == 16'd1) begin
          phase_nxt = (phase_r == PH_SBODY) ? PH_CLEN : PH_STAMP;
        end
      end
      PH_STAMP: begin
        ts_sh_nxt = {ts_sh_r[STAMP_SH_W-BYTE_W-1:0], s1_byte_r};
        cnt_nxt   = cnt_r + 3'd1;
        // Eighth byte completes the timestamp and the frame.
        if (cnt_r == 3'd7) begin
          have      = 1'b1;
          kind_nxt  = KIND_DONE;
          stamp_nxt = {ts_sh_r, s1_byte_r};
          phase_nxt = PH_SKIP;
        end
      end
      default: ;
    endcase

    // End of buffer: report truncation unless the frame already closed, then restart.
    if (s1_last_r) begin
      if (phase_nxt != PH_SKIP) begin
        have       = 1'b1;
        kind_nxt   = KIND_DONE;
        pbyte_nxt  = '0;
        stamp_nxt  = '0;
        status_nxt = ST_TRUNC;
      end
      phase_nxt  = PH_SLEN;
      cnt_nxt    = '0;
      len_sh_nxt = '0;
      rem_nxt    = '0;
      ts_sh_nxt  = '0;
    end
  end

  // Parse state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SLEN;
      cnt_r    <= '0;
      len_sh_r <= '0;
      rem_r    <= '0;
      ts_sh_r  <= '0;
    end else if (s1_adv) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      len_sh_r <= len_sh_nxt;
      rem_r    <= rem_nxt;
      ts_sh_r  <= ts_sh_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && have) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && have) begin
      kind_r   <= kind_nxt;
      pbyte_r  <= pbyte_nxt;
      stamp_r  <= stamp_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

FILE: hdl/lpmp_checker.sv
module lpmp_checker
  import lpmp_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [KIND_W-1:0]   out_kind,
  input logic [BYTE_W-1:0]   out_payload_byte,
  input logic [STAMP_W-1:0]  out_stamp,
  input logic [STATUS_W-1:0] out_status
);

  // No result is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_stamp)
      && $stable(out_status) && $stable(out_payload_byte))
    else $error("stalled result changed");

  // Byte results carry no status and no timestamp.
  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_SENDER || out_kind == KIND_CONTENT)
      |-> out_status == ST_OK && out_stamp == '0)
    else $error("byte result with status or timestamp");

  // A failed frame carries no timestamp and no byte.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DONE && out_status != ST_OK
      |-> out_stamp == '0 && out_payload_byte == '0)
    else $error("failed frame with timestamp or byte");

  // Only the three result kinds appear.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind == KIND_SENDER || out_kind == KIND_CONTENT
      || out_kind == KIND_DONE)
    else $error("undefined result kind");

endmodule

bind length_prefixed_message_parser lpmp_checker u_lpmp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_kind         (out_kind),
  .out_payload_byte (out_payload_byte),
  .out_stamp        (out_stamp),
  .out_status       (out_status)
);

FILE: verif/length_prefixed_message_parser_tb.sv
`timescale 1ns / 1ps

module length_prefixed_message_parser_tb;
  import lpmp_pkg::*;

  localparam int unsigned CLK_NS       = 8;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned LONG_HOLD    = 96;
  localparam int unsigned PRINT_CAP    = 40;

  // One result of the parser, in port order.
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   payload;
    logic [STAMP_W-1:0]  stamp;
    logic [STATUS_W-1:0] status;
  } frame_res_t;

  // One byte of the directed table, with an optional hand-written result.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              typed;
    frame_res_t        res;
  } byte_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_data_byte;
  logic                 in_end_of_buffer;
  logic                 out_valid;
  logic                 out_ready;
  logic [KIND_W-1:0]    out_kind;
  logic [BYTE_W-1:0]    out_payload_byte;
  logic [STAMP_W-1:0]   out_stamp;
  logic [STATUS_W-1:0]  out_status;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BOUND_W-1:0]   cfg_data;

  // Parser state as the testbench tracks it.
  logic [BOUND_W-1:0] bound_reg [0:(2**CFG_IDX_W)-1];
  phase_t             frame_phase;
  logic [CNT_W-1:0]   field_count;
  logic [LEN_W-1:0]   len_acc;
  logic [BOUND_W-1:0] body_left;
  logic [STAMP_W-1:0] stamp_acc;

  frame_res_t  parser_results [$];
  byte_row_t   cur_row;
  int unsigned bad_fields;
  int unsigned rand_items;
  int unsigned in_gap_max;
  int unsigned out_gap_max;
  bit          stall_req;

  length_prefixed_message_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_stamp        (out_stamp),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_NS / 2) clk = ~clk;
  end

  // A generous ceiling on the whole run.
  initial begin
    #(CLK_NS * LIMIT_CYCLES);
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (bad_fields < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    bad_fields++;
  endtask

  // Return the parser to its start phase, as the end flag and reset do.
  function automatic void clear_frame();
    frame_phase = PH_SLEN;
    field_count = '0;
    len_acc     = '0;
    body_left   = '0;
    stamp_acc   = '0;
  endfunction

  // Advance the parser by one byte; returns 1 when the byte yields a result.
  function automatic bit parse_byte(input logic [BYTE_W-1:0] b, input logic last,
                                    output frame_res_t r);
    bit              has_res;
    bit              sender_side;
    logic [LEN_W-1:0] lo;
    logic [LEN_W-1:0] hi;
    has_res = 1'b0;
    r = '0;
    case (frame_phase)
      PH_SLEN, PH_CLEN: begin
        sender_side = (frame_phase == PH_SLEN);
        len_acc = {len_acc[LEN_W-BYTE_W-1:0], b};
        field_count = field_count + 3'd1;
        if (field_count == 3'd4) begin
          lo = sender_side ? LEN_W'(bound_reg[REG_MIN_SENDER]) : LEN_W'(bound_reg[REG_MIN_CONTENT]);
          hi = sender_side ? LEN_W'(bound_reg[REG_MAX_SENDER]) : LEN_W'(bound_reg[REG_MAX_CONTENT]);
          if (len_acc < lo || len_acc > hi) begin
            has_res = 1'b1;
            r.kind = KIND_DONE;
            r.status = sender_side ? ST_BAD_SLEN : ST_BAD_CLEN;
            frame_phase = PH_SKIP;
          end else begin
            body_left = len_acc[BOUND_W-1:0];
            if (sender_side) begin
              frame_phase = (len_acc != 0) ? PH_SBODY : PH_CLEN;
            end else begin
              frame_phase = (len_acc != 0) ? PH_CBODY : PH_STAMP;
            end
          end
          field_count = '0;
          len_acc = '0;
        end
      end
      PH_SBODY, PH_CBODY: begin
        has_res = 1'b1;
        r.kind = (frame_phase == PH_SBODY) ? KIND_SENDER : KIND_CONTENT;
        r.payload = b;
        body_left = body_left - 16'd1;
        if (body_left == 0) begin
          frame_phase = (frame_phase == PH_SBODY) ? PH_CLEN : PH_STAMP;
        end
      end
      PH_STAMP: begin
        stamp_acc = {stamp_acc[STAMP_W-BYTE_W-1:0], b};
        field_count = field_count + 3'd1;
        if (field_count == 0) begin
          has_res = 1'b1;
          r.kind = KIND_DONE;
          r.status = ST_OK;
          r.stamp = stamp_acc;
          frame_phase = PH_SKIP;
        end
      end
      default: begin
      end
    endcase
    // The end flag reports an unfinished frame in place of any other result.
    if (last) begin
      if (frame_phase != PH_SKIP) begin
        has_res = 1'b1;
        r = '0;
        r.kind = KIND_DONE;
        r.status = ST_TRUNC;
      end
      clear_frame();
    end
    return has_res;
  endfunction

  // Watch all three channels at the rising edge.
  always @(posedge clk) begin : watch
    frame_res_t got;
    frame_res_t want;
    bit         has_res;
    if (rst_n) begin
      if (cfg_valid && cfg_ready && cfg_index <= REG_MAX_CONTENT) begin
        bound_reg[cfg_index] = cfg_data;
      end
      if (in_valid && in_ready) begin
        has_res = parse_byte(in_data_byte, in_end_of_buffer, want);
        if (cur_row.typed && (!has_res || want != cur_row.res)) begin
          report_mismatch($sformatf("directed byte %02h: parser gives %0b/%h, table says %h",
                                    cur_row.data, has_res, want, cur_row.res));
        end
        if (has_res) begin
          parser_results = {parser_results, want};
        end
      end
      if (out_valid && out_ready) begin
        got = {out_kind, out_payload_byte, out_stamp, out_status};
        if (parser_results.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing outstanding", got));
        end else begin
          want = parser_results.pop_front();
          if (got.kind !== want.kind) begin
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
          end
          if (got.payload !== want.payload) begin
            report_mismatch($sformatf("payload %02h, expected %02h", got.payload, want.payload));
          end
          if (got.stamp !== want.stamp) begin
            report_mismatch($sformatf("stamp %h, expected %h", got.stamp, want.stamp));
          end
          if (got.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          end
        end
      end
    end
  end

  // Result side: random stalls per result, plus an occasional long hold-off.
  initial begin : drain_side
    int unsigned wait_n;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        stall_req = 1'b0;
      end
      wait_n = $urandom_range(0, out_gap_max);
      if (wait_n != 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  function automatic byte_row_t bytes_row(input logic [BYTE_W-1:0] d, input logic last);
    byte_row_t rw;
    rw = '0;
    rw.data = d;
    rw.last = last;
    return rw;
  endfunction

  function automatic byte_row_t res_row(input logic [BYTE_W-1:0] d, input logic last,
                                        input logic [KIND_W-1:0] kind,
                                        input logic [BYTE_W-1:0] pay,
                                        input logic [STAMP_W-1:0] stamp,
                                        input logic [STATUS_W-1:0] status);
    byte_row_t rw;
    rw = bytes_row(d, last);
    rw.typed = 1'b1;
    rw.res = {kind, pay, stamp, status};
    return rw;
  endfunction

  // Offer one byte after a random gap; returns at the falling edge after its transfer.
  // The caller either offers the next byte or lowers in_valid in that same step.
  task automatic push_byte(input byte_row_t rw);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= rw.data;
    in_end_of_buffer <= rw.last;
    cur_row <= rw;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BOUND_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every result has arrived and the pipeline has settled.
  task automatic wait_idle();
    while (parser_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Pick a length field: mostly in range, sometimes just outside or far outside.
  function automatic logic [LEN_W-1:0] pick_len(input logic [BOUND_W-1:0] lo,
                                                input logic [BOUND_W-1:0] hi);
    int unsigned sel;
    int unsigned span;
    sel = $urandom_range(0, 7);
    if (sel == 0) begin
      return {BYTE_W'($urandom_range(1, 255)), 24'($urandom)};
    end
    if (sel == 1 && hi != '1) begin
      return LEN_W'(hi) + 1;
    end
    if (sel == 2 && lo != 0) begin
      return LEN_W'(lo) - 1;
    end
    if (lo > hi) begin
      return LEN_W'($urandom_range(0, 6));
    end
    span = (hi - lo > 6) ? 6 : int'(hi - lo);
    return LEN_W'(lo) + LEN_W'($urandom_range(0, span));
  endfunction

  // Send one buffer: usually a frame with random content, sometimes cut short,
  // and now and then plain noise.
  task automatic send_frame();
    logic [BYTE_W-1:0] fb [$];
    logic [LEN_W-1:0]  slen;
    logic [LEN_W-1:0]  clen;
    int unsigned       n;
    int unsigned       cut;
    int                k;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 10);
      repeat (n) push_byte(bytes_row(BYTE_W'($urandom), $urandom_range(0, 5) == 0));
      push_byte(bytes_row(BYTE_W'($urandom), 1'b1));
      rand_items += n + 1;
      return;
    end
    slen = pick_len(bound_reg[REG_MIN_SENDER], bound_reg[REG_MAX_SENDER]);
    for (k = 3; k >= 0; k--) fb = {fb, slen[BYTE_W*k +: BYTE_W]};
    n = (slen <= 16) ? slen : 3;
    repeat (n) fb = {fb, BYTE_W'($urandom)};
    clen = pick_len(bound_reg[REG_MIN_CONTENT], bound_reg[REG_MAX_CONTENT]);
    for (k = 3; k >= 0; k--) fb = {fb, clen[BYTE_W*k +: BYTE_W]};
    n = (clen <= 16) ? clen : 3;
    repeat (n) fb = {fb, BYTE_W'($urandom)};
    repeat (8) fb = {fb, BYTE_W'($urandom)};
    repeat ($urandom_range(0, 3)) fb = {fb, BYTE_W'($urandom)};
    // Cut some buffers short so the end flag lands anywhere in the frame.
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(0, fb.size() - 1);
      while (fb.size() > cut + 1) void'(fb.pop_back());
    end
    foreach (fb[i]) push_byte(bytes_row(fb[i], i == fb.size() - 1));
    rand_items += fb.size();
  endtask

  // Bound settings per phase: defaults, all zero, the full range, crossed sender
  // extremes, crossed content bounds, then random windows, mostly small.
  task automatic set_bounds(input int unsigned step);
    logic [BOUND_W-1:0]   lo_s;
    logic [BOUND_W-1:0]   hi_s;
    logic [BOUND_W-1:0]   lo_c;
    logic [BOUND_W-1:0]   hi_c;
    logic [CFG_IDX_W-1:0] idx;
    case (step)
      0: begin
        lo_s = MIN_SENDER_RST;
        hi_s = MAX_SENDER_RST;
        lo_c = MIN_CONTENT_RST;
        hi_c = MAX_CONTENT_RST;
      end
      1: begin
        lo_s = '0;
        hi_s = '0;
        lo_c = '0;
        hi_c = '0;
      end
      2: begin
        lo_s = '0;
        hi_s = '1;
        lo_c = '0;
        hi_c = '1;
      end
      3: begin
        lo_s = '1;
        hi_s = '0;
        lo_c = '1;
        hi_c = '1;
      end
      4: begin
        lo_s = 16'd1;
        hi_s = 16'd4;
        lo_c = 16'd9;
        hi_c = 16'd8;
      end
      default: begin
        lo_s = BOUND_W'($urandom_range(0, 3));
        hi_s = lo_s + BOUND_W'($urandom_range(0, 6));
        if ($urandom_range(0, 7) == 0 && lo_s != 0) begin
          hi_s = lo_s - 16'd1;
        end
        lo_c = BOUND_W'($urandom_range(0, 3));
        hi_c = ($urandom_range(0, 3) == 0) ? MAX_CONTENT_RST
                                           : lo_c + BOUND_W'($urandom_range(0, 10));
      end
    endcase
    write_reg(REG_MIN_SENDER, lo_s);
    write_reg(REG_MAX_SENDER, hi_s);
    write_reg(REG_MIN_CONTENT, lo_c);
    write_reg(REG_MAX_CONTENT, hi_c);
    // A write to an index past the last register must change nothing.
    if (step == 0 || $urandom_range(0, 3) == 0) begin
      do idx = CFG_IDX_W'($urandom); while (idx <= REG_MAX_CONTENT);
      write_reg(idx, BOUND_W'($urandom));
    end
  endtask

  function automatic int unsigned pick_gap();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 15;
    endcase
  endfunction

  initial begin : stimulus
    byte_row_t   directed [$];
    int unsigned step;
    int          k;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_end_of_buffer = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_row = '0;
    bad_fields = 0;
    rand_items = 0;
    stall_req = 1'b0;
    in_gap_max = 3;
    out_gap_max = 3;
    bound_reg[REG_MIN_SENDER] = MIN_SENDER_RST;
    bound_reg[REG_MAX_SENDER] = MAX_SENDER_RST;
    bound_reg[REG_MIN_CONTENT] = MIN_CONTENT_RST;
    bound_reg[REG_MAX_CONTENT] = MAX_CONTENT_RST;
    clear_frame();

    // Good frame under the reset bounds: one sender byte, one content byte,
    // and a timestamp whose last byte carries the end flag.
    for (k = 0; k < 3; k++) directed = {directed, bytes_row(8'h00, 1'b0)};
    directed = {directed, bytes_row(8'h01, 1'b0)};
    directed = {directed, res_row(8'hFF, 1'b0, KIND_SENDER, 8'hFF, '0, ST_OK)};
    for (k = 0; k < 3; k++) directed = {directed, bytes_row(8'h00, 1'b0)};
    directed = {directed, bytes_row(8'h01, 1'b0)};
    directed = {directed, res_row(8'h00, 1'b0, KIND_CONTENT, 8'h00, '0, ST_OK)};
    directed = {directed, bytes_row(8'hFF, 1'b0)};
    for (k = 0; k < 6; k++) directed = {directed, bytes_row(8'h00, 1'b0)};
    directed = {directed,
                res_row(8'hFF, 1'b1, KIND_DONE, 8'h00, 64'hFF00_0000_0000_00FF, ST_OK)};
    // Zero sender length is below the minimum; a trailing byte ends the buffer.
    for (k = 0; k < 3; k++) directed = {directed, bytes_row(8'h00, 1'b0)};
    directed = {directed, res_row(8'h00, 1'b0, KIND_DONE, 8'h00, '0, ST_BAD_SLEN)};
    directed = {directed, bytes_row(8'h77, 1'b1)};
    // The end flag on a sender byte replaces that byte with the truncation status.
    for (k = 0; k < 3; k++) directed = {directed, bytes_row(8'h00, 1'b0)};
    directed = {directed, bytes_row(8'h02, 1'b0)};
    directed = {directed, res_row(8'h5A, 1'b1, KIND_DONE, 8'h00, '0, ST_TRUNC)};
    // A content length of all ones, rejected on the flagged byte itself.
    for (k = 0; k < 3; k++) directed = {directed, bytes_row(8'h00, 1'b0)};
    directed = {directed, bytes_row(8'h01, 1'b0)};
    directed = {directed, bytes_row(8'h33, 1'b0)};
    for (k = 0; k < 3; k++) directed = {directed, bytes_row(8'hFF, 1'b0)};
    directed = {directed, res_row(8'hFF, 1'b1, KIND_DONE, 8'h00, '0, ST_BAD_CLEN)};

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) push_byte(directed[i]);
    in_valid <= 1'b0;

    // Random phases, each under its own bounds and idling mix.
    step = 0;
    while (rand_items < RANDOM_ITEMS) begin
      wait_idle();
      set_bounds(step);
      in_gap_max = pick_gap();
      out_gap_max = pick_gap();
      if (step % 3 == 1) begin
        stall_req = 1'b1;
        in_gap_max = 0;
      end
      repeat ($urandom_range(6, 12)) begin
        if (rand_items < RANDOM_ITEMS) send_frame();
      end
      in_valid <= 1'b0;
      step++;
    end

    while (parser_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (bad_fields == 0 && parser_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
